@@ rtl/dictionary_word_censor_core_defines.svh @@
// Assertion helpers shared by the checker.
`ifndef DICTIONARY_WORD_CENSOR_CORE_DEFINES_SVH
`define DICTIONARY_WORD_CENSOR_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is high
`define DWC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high
`define DWC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/dwc_pkg.sv @@
package dwc_pkg;

   localparam int CHAR_W = 8;

   // Request codes
   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_TEXT = 2'd1;
   localparam logic [1:0] REQ_EOL  = 2'd2;

   // Result codes
   localparam logic [1:0] KIND_LITERAL = 2'd0;
   localparam logic [1:0] KIND_MASKED  = 2'd1;
   localparam logic [1:0] KIND_EOL     = 2'd2;

   // Register file: byte address, 32-bit words
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_WORD_COUNT = '0;
   localparam int WORD_COUNT_W = 5;

   // Window slot control
   typedef struct packed {
      logic shift;
      logic load;
   } dwc_slot_ctl_type;

   // Dictionary entry control
   typedef struct packed {
      logic wr_en;
      logic eval;
      logic active;
   } dwc_entry_ctl_type;

endpackage

@@ rtl/dictionary_word_censor_core.sv @@
// Dictionary word censor. Load beats write dictionary bytes (one entry per
// cell, cleared by reset, so no clearing pass); text beats fill a lookahead
// window built as a chain of byte cells. Each time the window fills, every
// active entry compares its word against the window in parallel, a min tree
// picks the shortest hit, and one result beat (masked word or literal) is
// produced; the window chain then moves one slot per cycle for each byte
// dropped. A text beat that completes the window goes through accept,
// compare, select, then one shift per byte dropped (1 for a literal, the
// word length for a mask). An end-of-line beat repeats compare, select and
// shifts for each position flushed, then sends the line-end token. Results
// leave through an output register, so a stalled result does not block load
// or plain text beats. word_count is at byte address 0 of the register port.
module dictionary_word_censor_core #(
   parameter int MAX_WORDS    = 16,
   parameter int MAX_WORD_LEN = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_type,
   input  logic [3:0]                        req_word_index,
   input  logic [3:0]                        req_char_pos,
   input  logic [7:0]                        req_ch,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_kind,
   output logic [7:0]                        rsp_out_char,
   output logic [3:0]                        rsp_match_length,
   output logic                              rsp_last,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [dwc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import dwc_pkg::*;

   localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
   localparam int LEAVES = 1 << $clog2(MAX_WORDS);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MATCH = 3'd1;
   localparam logic [2:0] ST_EMIT  = 3'd2;
   localparam logic [2:0] ST_SHIFT = 3'd3;
   localparam logic [2:0] ST_EOL   = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [LEN_W-1:0]        fill_ff, fill_in;
   logic [LEN_W-1:0]        drop_ff, drop_in;
   logic                    flush_ff, flush_in;
   logic [WORD_COUNT_W-1:0] word_count_ff, word_count_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_char_ff, rsp_char_in;
   logic [3:0]  rsp_len_ff, rsp_len_in;
   logic        rsp_last_ff, rsp_last_in;

   logic req_accept, load_acc, text_acc, eol_acc, out_free, csr_write;

   logic [CHAR_W-1:0]                   slot_char [MAX_WORD_LEN];
   logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] win;
   dwc_slot_ctl_type                    slot_ctl  [MAX_WORD_LEN];
   dwc_entry_ctl_type                   entry_ctl [MAX_WORDS];
   logic [LEN_W-1:0]                    hit       [MAX_WORDS];
   logic [LEN_W-1:0]                    node      [2*LEAVES-1];
   logic [LEN_W-1:0]                    best;

   // Handshake decode
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign load_acc   = req_accept && (req_type == REQ_LOAD);
   assign text_acc   = req_accept && (req_type == REQ_TEXT);
   assign eol_acc    = req_accept && (req_type == REQ_EOL);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[CSR_ADDR_W-1:2] == CSR_IDX_WORD_COUNT);
   assign word_count_in = csr_write ? pwdata[WORD_COUNT_W-1:0] : word_count_ff;
   assign prdata = (paddr[CSR_ADDR_W-1:2] == CSR_IDX_WORD_COUNT)
                   ? 32'(word_count_ff) : '0;

   // Window chain
   for (genvar i = 0; i < MAX_WORD_LEN; i++) begin : g_slot
      logic [CHAR_W-1:0] next_c;
      if (i == MAX_WORD_LEN - 1) begin : g_tail
         assign next_c = '0;
      end else begin : g_body
         assign next_c = slot_char[i+1];
      end
      assign slot_ctl[i] = '{shift: (state_ff == ST_SHIFT),
                             load:  (text_acc && (fill_ff == LEN_W'(i)))};
      assign win[i] = slot_char[i];
      dwc_slot u_slot (
         .clock     (clock),
         .reset     (reset),
         .ctl       (slot_ctl[i]),
         .in_char   (req_ch),
         .next_char (next_c),
         .slot_char (slot_char[i])
      );
   end

   // Dictionary entries
   for (genvar j = 0; j < MAX_WORDS; j++) begin : g_entry
      assign entry_ctl[j] = '{wr_en:  (load_acc && (32'(req_word_index) == j)
                                       && (32'(req_char_pos) < MAX_WORD_LEN)),
                              eval:   (state_ff == ST_MATCH),
                              active: (32'(word_count_ff) > j)};
      dwc_entry #(.WORD_LEN(MAX_WORD_LEN)) u_entry (
         .clock   (clock),
         .reset   (reset),
         .ctl     (entry_ctl[j]),
         .wr_pos  (req_char_pos),
         .wr_char (req_ch),
         .win     (win),
         .fill    (fill_ff),
         .hit_len (hit[j])
      );
   end

   // Shortest non-zero hit: leaves then a binary tree
   for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
      if (j < MAX_WORDS) begin : g_used
         assign node[LEAVES-1+j] = hit[j];
      end else begin : g_pad
         assign node[LEAVES-1+j] = '0;
      end
   end
   for (genvar k = 0; k < LEAVES - 1; k++) begin : g_node
      assign node[k] = (node[2*k+1] == '0) ? node[2*k+2] :
                       (node[2*k+2] == '0) ? node[2*k+1] :
                       (node[2*k+1] < node[2*k+2]) ? node[2*k+1] : node[2*k+2];
   end
   assign best = node[0];

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      drop_in      = drop_ff;
      flush_in     = flush_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (text_acc) begin
               if (fill_ff < LEN_W'(MAX_WORD_LEN)) begin
                  fill_in = fill_ff + 1'b1;
               end
               if (fill_ff >= LEN_W'(MAX_WORD_LEN - 1)) begin
                  state_in = ST_MATCH;
                  flush_in = 1'b0;
               end
            end else if (eol_acc) begin
               flush_in = 1'b1;
               state_in = (fill_ff != '0) ? ST_MATCH : ST_EOL;
            end
         end
         ST_MATCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = !flush_ff;
               if (best != '0) begin
                  rsp_kind_in = KIND_MASKED;
                  rsp_char_in = '0;
                  rsp_len_in  = 4'(best);
                  drop_in     = best;
               end else begin
                  rsp_kind_in = KIND_LITERAL;
                  rsp_char_in = slot_char[0];
                  rsp_len_in  = '0;
                  drop_in     = LEN_W'(1);
               end
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            fill_in = fill_ff - 1'b1;
            drop_in = drop_ff - 1'b1;
            if (drop_ff == LEN_W'(1)) begin
               if (!flush_ff) begin
                  state_in = ST_IDLE;
               end else if (fill_ff == LEN_W'(1)) begin
                  state_in = ST_EOL;
               end else begin
                  state_in = ST_MATCH;
               end
            end
         end
         ST_EOL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_EOL;
               rsp_char_in  = '0;
               rsp_len_in   = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         drop_ff       <= '0;
         flush_ff      <= 1'b0;
         word_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         drop_ff       <= drop_in;
         flush_ff      <= flush_in;
         word_count_ff <= word_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_char_ff <= rsp_char_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_out_char     = rsp_char_ff;
   assign rsp_match_length = rsp_len_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

@@ rtl/dwc_slot.sv @@
module dwc_slot (
   input  logic                        clock,
   input  logic                        reset,
   input  dwc_pkg::dwc_slot_ctl_type   ctl,
   input  logic [dwc_pkg::CHAR_W-1:0]  in_char,
   input  logic [dwc_pkg::CHAR_W-1:0]  next_char,
   output logic [dwc_pkg::CHAR_W-1:0]  slot_char
);
   import dwc_pkg::*;

   logic [CHAR_W-1:0] char_ff;
   logic [CHAR_W-1:0] char_in;

   // shift takes the right neighbour's byte, load takes a new text byte
   always_comb begin
      char_in = char_ff;
      if (ctl.shift) begin
         char_in = next_char;
      end else if (ctl.load) begin
         char_in = in_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_ff <= '0;
      end else begin
         char_ff <= char_in;
      end
   end

   assign slot_char = char_ff;

endmodule

@@ rtl/dwc_entry.sv @@
module dwc_entry #(
   parameter  int WORD_LEN = 10,
   localparam int LEN_W    = $clog2(WORD_LEN + 1)
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  dwc_pkg::dwc_entry_ctl_type               ctl,
   input  logic [3:0]                               wr_pos,
   input  logic [dwc_pkg::CHAR_W-1:0]               wr_char,
   input  logic [WORD_LEN-1:0][dwc_pkg::CHAR_W-1:0] win,
   input  logic [LEN_W-1:0]                         fill,
   output logic [LEN_W-1:0]                         hit_len
);
   import dwc_pkg::*;

   logic [CHAR_W-1:0] chars_ff [WORD_LEN];
   logic [LEN_W-1:0]  hit_ff;
   logic [LEN_W-1:0]  hit_in;
   logic [LEN_W-1:0]  len_c;
   logic              run_c;
   logic              same_c;

   // word length is the leading run of non-zero bytes; compare that prefix
   always_comb begin
      run_c  = 1'b1;
      len_c  = '0;
      same_c = 1'b1;
      for (int i = 0; i < WORD_LEN; i++) begin
         run_c = run_c & (chars_ff[i] != '0);
         if (run_c) begin
            len_c  = LEN_W'(i + 1);
            same_c = same_c & (chars_ff[i] == win[i]);
         end
      end
      hit_in = (ctl.active && same_c && (len_c != '0) && (len_c <= fill)) ? len_c : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WORD_LEN; i++) begin
            chars_ff[i] <= '0;
         end
         hit_ff <= '0;
      end else begin
         for (int i = 0; i < WORD_LEN; i++) begin
            if (ctl.wr_en && (32'(wr_pos) == i)) begin
               chars_ff[i] <= wr_char;
            end
         end
         if (ctl.eval) begin
            hit_ff <= hit_in;
         end
      end
   end

   assign hit_len = hit_ff;

endmodule

@@ rtl/dwc_checker.sv @@
`include "dictionary_word_censor_core_defines.svh"

module dwc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_out_char,
   input logic [3:0] rsp_match_length,
   input logic       rsp_last
);
   import dwc_pkg::*;

   // a stalled result beat stays put
   `DWC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kind) && $stable(rsp_out_char) && $stable(rsp_match_length) && $stable(rsp_last), "result beat changed while stalled")

   // literal carries no length
   `DWC_ASSERT_NOW(a_literal, clock, reset, rsp_valid && (rsp_kind == KIND_LITERAL), rsp_match_length == 4'd0, "literal with non-zero length")

   // masked word carries no character
   `DWC_ASSERT_NOW(a_masked, clock, reset, rsp_valid && (rsp_kind == KIND_MASKED), rsp_out_char == 8'd0, "masked word with a character")

   // line end closes the beat group and is empty
   `DWC_ASSERT_NOW(a_line_end, clock, reset, rsp_valid && (rsp_kind == KIND_EOL), rsp_last && (rsp_out_char == 8'd0) && (rsp_match_length == 4'd0), "malformed line-end beat")

endmodule

bind dictionary_word_censor_core dwc_checker u_dwc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_out_char     (rsp_out_char),
   .rsp_match_length (rsp_match_length),
   .rsp_last         (rsp_last)
);

@@ tb/sv/dictionary_word_censor_core_tb.sv @@
module dictionary_word_censor_core_tb;
   import dwc_pkg::*;

   localparam int MAX_WORDS       = 16;
   localparam int MAX_WORD_LEN    = 10;
   localparam int BEAT_TARGET     = 430;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 40;
   localparam int TIMEOUT_CYCLES  = 3_000_000;

   // Request code the block has no use for
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_char;
      logic [3:0] match_length;
      logic       last;
   } token_type;

   // Censor predictor and the queue of tokens it owes
   class censor_scoreboard;
      logic [7:0] dict_bytes [MAX_WORDS][MAX_WORD_LEN];
      logic [7:0] window [MAX_WORD_LEN];
      int         fill;
      logic [4:0] word_count;
      token_type  tokens_due [$];
      int         errors;

      function new();
         foreach (dict_bytes[j, i]) dict_bytes[j][i] = 8'h00;
         foreach (window[i]) window[i] = 8'h00;
         fill = 0;
         word_count = '0;
         errors = 0;
      endfunction

      function void set_word_count(logic [4:0] v);
         word_count = v;
      endfunction

      function int pending();
         return tokens_due.size();
      endfunction

      // run of non-zero bytes from position 0
      function int entry_length(int j);
         int n;
         n = 0;
         while (n < MAX_WORD_LEN && dict_bytes[j][n] != 8'h00) n++;
         return n;
      endfunction

      // decide the head of the window: shortest matching word, else literal
      function void decide_head(logic last_flag);
         int        n, best, len, drop;
         bit        same;
         token_type tok;
         n = (word_count > MAX_WORDS) ? MAX_WORDS : int'(word_count);
         best = 0;
         for (int j = 0; j < n; j++) begin
            len = entry_length(j);
            if (len == 0 || len > fill) continue;
            if (best != 0 && len >= best) continue;
            same = 1'b1;
            for (int i = 0; i < len; i++)
               if (dict_bytes[j][i] != window[i]) same = 1'b0;
            if (same) best = len;
         end
         tok.last = last_flag;
         if (best != 0) begin
            tok.kind = KIND_MASKED;
            tok.out_char = 8'h00;
            tok.match_length = 4'(best);
            drop = best;
         end else begin
            tok.kind = KIND_LITERAL;
            tok.out_char = window[0];
            tok.match_length = 4'h0;
            drop = 1;
         end
         for (int i = 0; i < MAX_WORD_LEN; i++)
            window[i] = (i + drop < fill) ? window[i + drop] : 8'h00;
         fill -= drop;
         tokens_due.push_back(tok);
      endfunction

      // accepted input beat
      function void note_beat(logic [1:0] t, logic [3:0] widx, logic [3:0] pos,
                              logic [7:0] c);
         int        k;
         token_type tok;
         case (t)
            REQ_LOAD: begin
               if (pos < MAX_WORD_LEN) dict_bytes[widx][pos] = c;
            end
            REQ_TEXT: begin
               if (fill < MAX_WORD_LEN) begin
                  window[fill] = c;
                  fill++;
               end
               if (fill >= MAX_WORD_LEN) decide_head(1'b1);
            end
            REQ_EOL: begin
               k = 0;
               while (fill > 0 && k < MAX_WORD_LEN - 1) begin
                  decide_head(1'b0);
                  k++;
               end
               tok.kind = KIND_EOL;
               tok.out_char = 8'h00;
               tok.match_length = 4'h0;
               tok.last = 1'b1;
               tokens_due.push_back(tok);
            end
            default: ;
         endcase
      endfunction

      // accepted result beat against the oldest expected token
      function void check_beat(token_type got);
         token_type want;
         if (tokens_due.size() == 0) begin
            $error("result beat with nothing expected: kind %0d char %0h length %0d last %0b",
                   got.kind, got.out_char, got.match_length, got.last);
            errors++;
            return;
         end
         want = tokens_due.pop_front();
         if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            errors++;
         end
         if (got.out_char !== want.out_char) begin
            $error("out_char: expected %0h, got %0h", want.out_char, got.out_char);
            errors++;
         end
         if (got.match_length !== want.match_length) begin
            $error("match_length: expected %0d, got %0d", want.match_length, got.match_length);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_type = '0;
   logic [3:0]            req_word_index = '0;
   logic [3:0]            req_char_pos = '0;
   logic [7:0]            req_ch = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_kind;
   logic [7:0]            rsp_out_char;
   logic [3:0]            rsp_match_length;
   logic                  rsp_last;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   bit               calm = 1'b0;
   bit               hold_off_req = 1'b0;
   int               beats_sent = 0;
   censor_scoreboard sb;

   dictionary_word_censor_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_word_index   (req_word_index),
      .req_char_pos     (req_char_pos),
      .req_ch           (req_ch),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_out_char     (rsp_out_char),
      .rsp_match_length (rsp_match_length),
      .rsp_last         (rsp_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // idle run length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // dictionary byte: mostly a few letters so that words recur
   function automatic logic [7:0] rand_letter();
      if ($urandom_range(0, 99) < 88) return 8'($urandom_range(8'h61, 8'h64));
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic logic [7:0] rand_text_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 8'($urandom_range(8'h61, 8'h65));
      if (r < 75) return 8'h00;
      return 8'($urandom_range(0, 255));
   endfunction

   // one input beat, held until accepted; called and returns at a rising edge
   task automatic send_beat(logic [1:0] t, logic [3:0] widx, logic [3:0] pos,
                            logic [7:0] c);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= t;
      req_word_index <= widx;
      req_char_pos   <= pos;
      req_ch         <= c;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.note_beat(t, widx, pos, c);
      if (t != REQ_UNUSED) beats_sent++;
   endtask

   task automatic send_text(logic [7:0] c);
      send_beat(REQ_TEXT, 4'($urandom), 4'($urandom), c);
   endtask

   task automatic send_load(logic [3:0] widx, logic [3:0] pos, logic [7:0] c);
      send_beat(REQ_LOAD, widx, pos, c);
   endtask

   task automatic send_eol();
      send_beat(REQ_EOL, 4'($urandom), 4'($urandom), 8'($urandom));
   endtask

   // stop offering, wait for every owed token, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write: setup cycle then access cycle
   task automatic write_word_count(logic [4:0] v);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {CSR_IDX_WORD_COUNT, 2'b00};
      pwdata  <= 32'(v);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_word_count(v);
   endtask

   // result side: check accepted beats, choose the stall for the next cycle
   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_beat({rsp_kind, rsp_out_char, rsp_match_length, rsp_last});
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left = HOLD_OFF_CYCLES;
         end
         if (stall_left == 0) stall_left = pick_gap();
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      #(4 * TIMEOUT_CYCLES);
      $display("dictionary_word_censor_core test failed");
      $finish;
   end

   initial begin : stimulus
      int         n_active, j, len, r, phase;
      logic [4:0] wc;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no active words: zero byte and top byte both come out as literals
      send_text(8'h00);
      send_text(8'hFF);
      send_eol();
      drain();

      // count above the store size acts as the whole store
      write_word_count(5'd31);
      send_load(4'd15, 4'd0, 8'h71);
      send_load(4'd3, 4'd0, 8'h71);
      send_load(4'd3, 4'd1, 8'h7A);
      send_load(4'd4, 4'd0, 8'h7A);
      send_load(4'd4, 4'd1, 8'h71);
      // position past the entry is dropped; entry 7 left empty
      send_load(4'd0, 4'd12, 8'h6B);
      send_load(4'd7, 4'd0, 8'h00);
      send_beat(REQ_UNUSED, 4'hF, 4'hF, 8'hFF);
      // "q" beats "qz" as the shorter word, then a flush of literals
      send_text(8'h71);
      send_text(8'h7A);
      repeat (8) send_text(8'hFF);
      send_eol();
      // near line end "zq" is longer than what is left
      send_text(8'h7A);
      send_eol();

      phase = 0;
      while (beats_sent < BEAT_TARGET) begin
         drain();
         case (phase % 6)
            0: wc = 5'd16;
            1: wc = 5'd0;
            2: wc = 5'd31;
            3: wc = 5'd1;
            default: wc = 5'($urandom_range(0, 31));
         endcase
         calm = (phase % 7 == 4);
         write_word_count(wc);

         // rewrite a few entries, some left empty
         if (phase % 3 == 0) begin
            repeat ($urandom_range(2, 6)) begin
               j = $urandom_range(0, MAX_WORDS - 1);
               r = $urandom_range(0, 99);
               len = (r < 10) ? 0 : (r < 80) ? $urandom_range(1, 4)
                                             : $urandom_range(5, MAX_WORD_LEN);
               for (int p = 0; p < len; p++) send_load(4'(j), 4'(p), rand_letter());
               if (len < MAX_WORD_LEN) send_load(4'(j), 4'(len), 8'h00);
            end
         end

         // long hold-off on the result side while text keeps coming
         if (phase == 2) hold_off_req = 1'b1;

         n_active = (wc > MAX_WORDS) ? MAX_WORDS : int'(wc);
         repeat ($urandom_range(1, 4)) begin
            repeat ((phase == 2) ? 40 : $urandom_range(0, 20)) begin
               r = $urandom_range(0, 99);
               if (r < 4) begin
                  send_beat(REQ_UNUSED, 4'($urandom), 4'($urandom), 8'($urandom));
               end else if (r < 7) begin
                  send_load(4'($urandom), 4'($urandom_range(10, 15)), 8'($urandom));
               end else if (r < 55 && n_active > 0) begin
                  j = $urandom_range(0, n_active - 1);
                  len = sb.entry_length(j);
                  if (len == 0) send_text(rand_text_char());
                  for (int i = 0; i < len; i++) send_text(sb.dict_bytes[j][i]);
               end else begin
                  send_text(rand_text_char());
               end
            end
            send_eol();
         end
         phase++;
      end

      drain();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("dictionary_word_censor_core test passed");
      end else begin
         $display("dictionary_word_censor_core test failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/dwc_pkg.sv
rtl/dwc_slot.sv
rtl/dwc_entry.sv
rtl/dictionary_word_censor_core.sv
rtl/dwc_checker.sv
tb/sv/dictionary_word_censor_core_tb.sv
